// ===== hdl/packet_redirect_and_neighbor_learn_defines.svh =====
// assertion macros for the frame classifier
`ifndef PACKET_REDIRECT_AND_NEIGHBOR_LEARN_DEFINES_SVH
`define PACKET_REDIRECT_AND_NEIGHBOR_LEARN_DEFINES_SVH
`ifndef ASSERT_OFF
`define PRNL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PRNL_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PRNL_ASSERT(label, clk, rst, prop, msg)
`define PRNL_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== hdl/prnl_pkg.sv =====
package prnl_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned QueueDepth = 4;

  localparam logic [CfgIdxW-1:0] REG_EXTERNAL_PORT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CONTROL_PORT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_EPHEMERAL_START = 2'd2;

  localparam logic [15:0] EPHEMERAL_RESET = 16'd61000;
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;
  localparam logic [15:0] ETH_ARP = 16'h0806;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] PROTO_ICMP6 = 8'd58;
  localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
  localparam logic [7:0] ICMP6_ECHO_REQUEST = 8'd128;
  localparam logic [7:0] ICMP6_ECHO_REPLY = 8'd129;
  localparam logic [7:0] ICMP6_NEIGH_ADV = 8'd136;
  localparam logic [7:0] OPT_TARGET_LL = 8'd2;
  localparam logic [47:0] ARP_ETH_IPV4 = 48'h000108000604;

  typedef enum logic [1:0] {
    KIND_ARP = 2'd0,
    KIND_ICMP4 = 2'd1,
    KIND_ICMP6 = 2'd2,
    KIND_ADVERT = 2'd3
  } learn_kind_t;

  // fields captured by the front for one frame
  typedef struct packed {
    logic [6:0] len;
    logic [47:0] eth_source;
    logic [15:0] eth_kind;
    logic [7:0] proto;
    logic [3:0] ihl;
    logic [15:0] frag;
    logic [63:0] src_high;
    logic [63:0] src_low;
    logic [15:0] udp_dest;
    logic [7:0] itype;
    logic [7:0] iflags;
    logic [63:0] option;
    logic [47:0] arp_check;
  } frame_rec_t;

  typedef struct packed {
    logic redirect;
    logic learn_valid;
    logic [1:0] learn_kind;
    logic [63:0] learn_ip_high;
    logic [63:0] learn_ip_low;
    logic [47:0] learn_mac;
  } verdict_t;

endpackage

// ===== hdl/prnl_if.sv =====
interface prnl_in_if;
  logic valid;
  logic ready;
  logic [7:0] frame_byte;
  logic frame_end;
  modport source(output valid, frame_byte, frame_end, input ready);
  modport sink(input valid, frame_byte, frame_end, output ready);
endinterface

interface prnl_out_if;
  logic valid;
  logic ready;
  logic redirect;
  logic learn_valid;
  logic [1:0] learn_kind;
  logic [63:0] learn_ip_high;
  logic [63:0] learn_ip_low;
  logic [47:0] learn_mac;
  modport source(output valid, redirect, learn_valid, learn_kind, learn_ip_high,
                 learn_ip_low, learn_mac, input ready);
  modport sink(input valid, redirect, learn_valid, learn_kind, learn_ip_high,
               learn_ip_low, learn_mac, output ready);
endinterface

// ===== hdl/prnl_front.sv =====
module prnl_front (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  input logic [7:0] frame_byte,
  input logic frame_end,
  output logic rec_valid,
  input logic rec_ready,
  output prnl_pkg::frame_rec_t rec
);
  import prnl_pkg::*;

  logic [6:0] pos;
  frame_rec_t cur;
  frame_rec_t cur_next;
  logic take;

  // only the last byte needs queue room
  assign in_ready = rec_ready || !frame_end;
  assign take = in_valid && in_ready;

  // field capture by byte position
  always_comb begin
    cur_next = cur;
    if (pos >= 7'd6 && pos <= 7'd11) begin
      cur_next.eth_source = {cur.eth_source[39:0], frame_byte};
    end else if (pos == 7'd12 || pos == 7'd13) begin
      cur_next.eth_kind = {cur.eth_kind[7:0], frame_byte};
    end else if (cur.eth_kind == ETH_IPV4) begin
      if (pos == 7'd14) cur_next.ihl = frame_byte[3:0];
      else if (pos == 7'd20 || pos == 7'd21) cur_next.frag = {cur.frag[7:0], frame_byte};
      else if (pos == 7'd23) cur_next.proto = frame_byte;
      else if (pos >= 7'd26 && pos <= 7'd29)
        cur_next.src_low = {cur.src_low[55:0], frame_byte};
      else if (pos == 7'd34) cur_next.itype = frame_byte;
      else if (pos == 7'd36 || pos == 7'd37)
        cur_next.udp_dest = {cur.udp_dest[7:0], frame_byte};
    end else if (cur.eth_kind == ETH_IPV6) begin
      if (pos == 7'd20) cur_next.proto = frame_byte;
      else if (pos >= 7'd22 && pos <= 7'd29)
        cur_next.src_high = {cur.src_high[55:0], frame_byte};
      else if (pos >= 7'd30 && pos <= 7'd37)
        cur_next.src_low = {cur.src_low[55:0], frame_byte};
      else if (pos == 7'd54) cur_next.itype = frame_byte;
      else if (pos == 7'd56 || pos == 7'd57)
        cur_next.udp_dest = {cur.udp_dest[7:0], frame_byte};
      else if (pos == 7'd58) cur_next.iflags = frame_byte;
      else if (pos >= 7'd78 && pos <= 7'd85)
        cur_next.option = {cur.option[55:0], frame_byte};
    end else if (cur.eth_kind == ETH_ARP) begin
      if (pos >= 7'd14 && pos <= 7'd19)
        cur_next.arp_check = {cur.arp_check[39:0], frame_byte};
      else if (pos >= 7'd22 && pos <= 7'd27)
        cur_next.option = {16'd0, cur.option[39:0], frame_byte};
      else if (pos >= 7'd28 && pos <= 7'd31)
        cur_next.src_low = {cur.src_low[55:0], frame_byte};
    end
    if (pos != 7'd127) cur_next.len = pos + 7'd1;
    else cur_next.len = pos;
  end

  // frame state, cleared after each frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      cur <= '0;
    end else if (take) begin
      if (frame_end) begin
        pos <= '0;
        cur <= '0;
      end else begin
        pos <= cur_next.len;
        cur <= cur_next;
      end
    end
  end

  assign rec_valid = take && frame_end;
  assign rec = cur_next;
endmodule

// ===== hdl/prnl_back.sv =====
`include "packet_redirect_and_neighbor_learn_defines.svh"
module prnl_back #(
  parameter int unsigned Depth = prnl_pkg::QueueDepth
) (
  input logic clk,
  input logic rst,
  input logic rec_valid,
  output logic rec_ready,
  input prnl_pkg::frame_rec_t rec,
  input logic [15:0] external_port,
  input logic [15:0] control_port,
  input logic [15:0] ephemeral_start,
  output logic out_valid,
  input logic out_ready,
  output prnl_pkg::verdict_t verdict
);
  import prnl_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  frame_rec_t q [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0] count;
  logic push;
  logic pop;
  frame_rec_t h;
  verdict_t v;
  logic hit;
  logic load;

  assign rec_ready = (count != Depth[PtrW:0]);
  assign push = rec_valid && rec_ready;
  assign load = !out_valid || out_ready;
  assign pop = (count != '0) && load;
  assign h = q[rd_ptr];

  // record queue between front and back
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + {{PtrW{1'b0}}, push} - {{PtrW{1'b0}}, pop};
    end
  end

  // verdict decode
  always_comb begin
    hit = (h.udp_dest == external_port) || (h.udp_dest == control_port) ||
          (h.udp_dest >= ephemeral_start);
    v = '0;
    if (h.len >= 7'd14) begin
      if (h.eth_kind == ETH_IPV4 && h.len >= 7'd34) begin
        if (h.proto == PROTO_UDP) begin
          if (h.ihl == 4'd5 && (h.frag & 16'hBFFF) == 16'd0 && h.len >= 7'd42)
            v.redirect = hit;
        end else if (h.proto == PROTO_ICMP) begin
          if (h.len >= 7'd38 && h.itype == ICMP_ECHO_REPLY) begin
            v.learn_valid = 1'b1;
            v.learn_kind = KIND_ICMP4;
            v.learn_ip_low = {32'h0000FFFF, h.src_low[31:0]};
            v.learn_mac = h.eth_source;
          end
        end
      end else if (h.eth_kind == ETH_IPV6 && h.len >= 7'd54) begin
        if (h.proto == PROTO_UDP) begin
          if (h.len >= 7'd62) v.redirect = hit;
        end else if (h.proto == PROTO_ICMP6 && h.len >= 7'd58) begin
          if (h.itype == ICMP6_NEIGH_ADV) begin
            if (h.len >= 7'd78 && h.iflags[6]) begin
              v.learn_valid = 1'b1;
              v.learn_kind = KIND_ADVERT;
              v.learn_ip_high = h.src_high;
              v.learn_ip_low = h.src_low;
              if (h.len >= 7'd86 && h.option[63:56] == OPT_TARGET_LL &&
                  h.option[55:48] == 8'd1)
                v.learn_mac = h.option[47:0];
              else
                v.learn_mac = h.eth_source;
            end
          end else if (h.itype == ICMP6_ECHO_REPLY) begin
            v.learn_valid = 1'b1;
            v.learn_kind = KIND_ICMP6;
            v.learn_ip_high = h.src_high;
            v.learn_ip_low = h.src_low;
            v.learn_mac = h.eth_source;
          end
        end
      end else if (h.eth_kind == ETH_ARP && h.len >= 7'd42) begin
        if (h.arp_check == ARP_ETH_IPV4) begin
          v.learn_valid = 1'b1;
          v.learn_kind = KIND_ARP;
          v.learn_ip_low = {32'h0000FFFF, h.src_low[31:0]};
          v.learn_mac = h.option[47:0];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load) out_valid <= (count != '0);
  end

  always_ff @(posedge clk) begin
    if (pop) verdict <= v;
  end

  `PRNL_ASSERT(a_count_bound, clk, rst, count <= Depth[PtrW:0], "queue overfilled")
  `PRNL_ASSERT(a_no_push_full, clk, rst, (count == Depth[PtrW:0]) |-> !push, "push when full")
  `PRNL_ASSERT(a_hold_stall, clk, rst, (out_valid && !out_ready) |=> $stable(verdict), "stall")
  `PRNL_ASSERT_RST(a_reset_empty, clk, rst |=> (count == '0 && !out_valid), "reset not empty")
endmodule

// ===== hdl/packet_redirect_and_neighbor_learn.sv =====
// Frame classifier with neighbor learning.
// The in channel takes one Ethernet frame byte per transaction, with
// frame_end marking the last byte. For every frame the out channel gives
// one transaction: redirect (UDP to the external or control port or at or
// above ephemeral_start) and an optional learned IP/MAC pair from ARP,
// ICMP echo replies or solicited neighbor advertisements.
// Throughput is one byte per cycle unless the queue is full at a frame's
// last byte; the byte capture in the front keeps up at line rate and the
// back decodes one frame per cycle while the output is not stalled. The
// record enters the queue when the last byte is accepted; its verdict is
// decoded from the queue head and loaded into the output register.
// If the receiver stalls, verdicts wait in the output register and the
// record queue (QueueDepth frames); when it is full the in channel drops
// ready at a frame's last byte. Configuration is written through cfg_we,
// cfg_index and cfg_data while idle. Synchronous reset empties the queue,
// clears the frame state and restores the port registers.
module packet_redirect_and_neighbor_learn #(
  parameter int unsigned QueueDepth = prnl_pkg::QueueDepth
) (
  input logic clk,
  input logic rst,
  prnl_in_if.sink in_ch,
  prnl_out_if.source out_ch,
  input logic cfg_we,
  input logic [prnl_pkg::CfgIdxW-1:0] cfg_index,
  input logic [prnl_pkg::CfgDataW-1:0] cfg_data
);
  import prnl_pkg::*;

  logic [15:0] external_port;
  logic [15:0] control_port;
  logic [15:0] ephemeral_start;
  logic rec_valid;
  logic rec_ready;
  frame_rec_t rec;
  verdict_t verdict;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      external_port <= '0;
      control_port <= '0;
      ephemeral_start <= EPHEMERAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXTERNAL_PORT: external_port <= cfg_data;
        REG_CONTROL_PORT: control_port <= cfg_data;
        REG_EPHEMERAL_START: ephemeral_start <= cfg_data;
        default: ;
      endcase
    end
  end

  prnl_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .frame_byte(in_ch.frame_byte), .frame_end(in_ch.frame_end),
    .rec_valid(rec_valid), .rec_ready(rec_ready), .rec(rec)
  );

  prnl_back #(.Depth(QueueDepth)) u_back (
    .clk(clk), .rst(rst),
    .rec_valid(rec_valid), .rec_ready(rec_ready), .rec(rec),
    .external_port(external_port), .control_port(control_port),
    .ephemeral_start(ephemeral_start),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .verdict(verdict)
  );

  assign out_ch.redirect = verdict.redirect;
  assign out_ch.learn_valid = verdict.learn_valid;
  assign out_ch.learn_kind = verdict.learn_kind;
  assign out_ch.learn_ip_high = verdict.learn_ip_high;
  assign out_ch.learn_ip_low = verdict.learn_ip_low;
  assign out_ch.learn_mac = verdict.learn_mac;
endmodule
